### rtl/ema_pkg.sv
package ema_pkg;

   // Fixed field and register widths.
   localparam int SAMPLE_WIDTH    = 32;
   localparam int FRACTION_BITS   = 16;
   localparam int PERIOD_WIDTH    = 8;
   localparam int SMOOTH_WIDTH    = 16;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD    = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SMOOTHING = 1'b1;

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 8'd20;
   localparam logic [SMOOTH_WIDTH-1:0] SMOOTH_RESET = 16'd6242;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic seed_acc;
      logic div_step;
      logic div_fix;
      logic mul_lo;
      logic mul_hi;
      logic update;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic seeded;
      logic seed_last;
      logic div_last;
   } sts_type;

endpackage

### rtl/ema_with_sma_seed.sv
// Exponential moving average seeded with a simple mean, one item at a time.
// The first period samples are summed; the last of them returns their mean
// (truncated toward zero) with is_seed set, and every later sample returns
// avg + floor(smoothing * (sample - avg) / 2^16). The average is held at the
// width of the seed sum, since lowering the period during seeding can give a
// mean beyond the sample range; the result carries its low SAMPLE_WIDTH bits.
// A seeding sample that gives no result only adds to the sum. The sample that
// completes the seed goes through the bit-serial divider, which does one
// quotient bit per cycle over the SAMPLE_WIDTH + 8 bit sum. Every later sample
// makes two passes through one 17-bit by (SAMPLE_WIDTH / 2 + 6)-bit multiplier,
// followed by the add. The result sits in an output register, so the next item
// is taken while it waits; an item only waits if its own result finds the
// output still held. Configuration is to be written only while the block is
// idle; the block itself does not enforce this.
module ema_with_sma_seed #(
   parameter int SAMPLE_WIDTH = ema_pkg::SAMPLE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_average,
   output logic                                rsp_is_seed,
   input  logic                                csr_wen,
   input  logic [ema_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ema_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   ema_pkg::cmd_type cmd;
   ema_pkg::sts_type sts;

   ema_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ema_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_sample  (req_sample),
      .rsp_average (rsp_average),
      .rsp_is_seed (rsp_is_seed),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts)
   );

   // Items are worked one at a time, so an accept is never followed by another.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted in two consecutive cycles");

   // The divider only runs before the average has been seeded.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !sts.seeded)
      else $error("divider stepped after seeding");

   // The smoothing update only runs once the average has been seeded.
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> sts.seeded)
      else $error("average updated before seeding");

endmodule

### rtl/ema_ctrl.sv
module ema_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  ema_pkg::sts_type sts,
   output ema_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SEED = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FIX  = 3'd3;
   localparam logic [2:0] S_MLO  = 3'd4;
   localparam logic [2:0] S_MHI  = 3'd5;
   localparam logic [2:0] S_UPD  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.seeded ? S_MLO : S_SEED;
            end
         end
         S_SEED: begin
            cmd.seed_acc = 1'b1;
            state_in     = sts.seed_last ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.div_fix = 1'b1;
            state_in    = S_OUT;
         end
         S_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MHI;
         end
         S_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            // Wait here only while the previous result still sits unclaimed.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/ema_dp.sv
module ema_dp #(
   parameter int SAMPLE_WIDTH = ema_pkg::SAMPLE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_average,
   output logic                                rsp_is_seed,
   input  logic                                csr_wen,
   input  logic [ema_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ema_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  ema_pkg::cmd_type                    cmd,
   output ema_pkg::sts_type                    sts
);

   localparam int SW   = SAMPLE_WIDTH;
   localparam int PRW  = ema_pkg::PERIOD_WIDTH;
   localparam int SMW  = ema_pkg::SMOOTH_WIDTH;
   localparam int SUMW = SW + PRW;            // holds the sum of up to 255 samples
   localparam int DW   = SUMW + 1;            // sample minus average
   localparam int H    = (DW + 1) / 2;        // low half of the difference
   localparam int HB   = H + 1;               // signed multiplier operand
   localparam int MW   = SMW + 1 + HB;        // multiplier product
   localparam int LW   = H + SMW;             // low partial product, unsigned
   localparam int PW   = DW + SMW + 1;        // full product
   localparam int CW   = $clog2(SUMW);

   // Configuration registers.
   logic [PRW-1:0] period_ff, period_in;
   logic [SMW-1:0] smooth_ff, smooth_in;

   // Architectural state. The average keeps the width of the sum, because a
   // seed taken after the period was lowered can fall outside the sample range.
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic [PRW-1:0]         count_ff, count_in;
   logic signed [SUMW-1:0] avg_ff, avg_in;
   logic                   seeded_ff, seeded_in;
   logic                   seed_flag_ff, seed_flag_in;

   // Work registers.
   logic signed [SW-1:0] x_ff, x_in;
   logic signed [DW-1:0] diff_ff, diff_in;
   logic [LW-1:0]        lo_ff, lo_in;
   logic signed [MW-1:0] hi_ff, hi_in;
   logic [SUMW-1:0]      q_ff, q_in;
   logic [PRW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic signed [SW-1:0] out_avg_ff, out_avg_in;
   logic                 out_seed_ff, out_seed_in;

   logic [PRW-1:0]         p_eff;
   logic                   seed_last;
   logic signed [SUMW-1:0] new_sum;
   logic [PRW:0]           trial;
   logic [PRW:0]           trial_sub;
   logic signed [SUMW-1:0] quot;
   logic signed [HB-1:0]   mul_b;
   logic signed [MW-1:0]   mul_p;
   logic signed [PW-1:0]   hi_ext, lo_ext, full;
   logic signed [DW-1:0]   step, avg_next;

   // A period of zero behaves as a period of one.
   assign p_eff     = (period_ff == '0) ? PRW'(1) : period_ff;
   assign seed_last = ({1'b0, count_ff} + (PRW + 1)'(1)) >= {1'b0, p_eff};
   assign new_sum   = sum_ff + SUMW'(x_ff);

   // One restoring division step on the magnitude of the sum.
   assign trial     = {rem_ff, q_ff[SUMW-1]};
   assign trial_sub = trial - {1'b0, p_eff};
   assign quot      = neg_ff ? -$signed(q_ff) : $signed(q_ff);

   // The difference goes through one 17 by HB multiplier in two halves.
   always_comb begin
      if (cmd.mul_hi) begin
         mul_b = HB'($signed(diff_ff[DW-1:H]));
      end else begin
         mul_b = $signed({1'b0, diff_ff[H-1:0]});
      end
   end
   assign mul_p = $signed({1'b0, smooth_ff}) * mul_b;

   always_comb begin
      hi_ext   = PW'(hi_ff);
      lo_ext   = PW'(lo_ff);
      full     = (hi_ext <<< H) + lo_ext;
      step     = DW'(full >>> ema_pkg::FRACTION_BITS);
      avg_next = DW'(avg_ff) + step;
   end

   always_comb begin
      period_in    = period_ff;
      smooth_in    = smooth_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      avg_in       = avg_ff;
      seeded_in    = seeded_ff;
      seed_flag_in = seed_flag_ff;
      x_in         = x_ff;
      diff_in      = diff_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      out_avg_in   = out_avg_ff;
      out_seed_in  = out_seed_ff;

      if (csr_wen) begin
         case (csr_index)
            ema_pkg::CSR_PERIOD:    period_in = csr_wdata[PRW-1:0];
            ema_pkg::CSR_SMOOTHING: smooth_in = csr_wdata[SMW-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         x_in    = req_sample;
         diff_in = DW'(req_sample) - DW'(avg_ff);
      end

      if (cmd.seed_acc) begin
         if (seed_last) begin
            q_in     = new_sum[SUMW-1] ? SUMW'(-new_sum) : SUMW'(new_sum);
            neg_in   = new_sum[SUMW-1];
            rem_in   = '0;
            cnt_in   = '0;
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = new_sum;
            count_in = count_ff + PRW'(1);
         end
      end

      if (cmd.div_step) begin
         if (!trial_sub[PRW]) begin
            rem_in = trial_sub[PRW-1:0];
            q_in   = {q_ff[SUMW-2:0], 1'b1};
         end else begin
            rem_in = trial[PRW-1:0];
            q_in   = {q_ff[SUMW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
      end

      if (cmd.div_fix) begin
         avg_in       = quot;
         seeded_in    = 1'b1;
         seed_flag_in = 1'b1;
      end

      if (cmd.mul_lo) begin
         lo_in = lo_ff;
         lo_in = mul_p[LW-1:0];
      end

      if (cmd.mul_hi) begin
         hi_in = mul_p;
      end

      if (cmd.update) begin
         avg_in       = avg_next[SUMW-1:0];
         seed_flag_in = 1'b0;
      end

      if (cmd.load_out) begin
         out_avg_in  = avg_ff[SW-1:0];
         out_seed_in = seed_flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= ema_pkg::PERIOD_RESET;
         smooth_ff <= ema_pkg::SMOOTH_RESET;
         sum_ff    <= '0;
         count_ff  <= '0;
         avg_ff    <= '0;
         seeded_ff <= 1'b0;
      end else begin
         period_ff <= period_in;
         smooth_ff <= smooth_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         avg_ff    <= avg_in;
         seeded_ff <= seeded_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_flag_ff <= seed_flag_in;
      x_ff         <= x_in;
      diff_ff      <= diff_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      out_avg_ff   <= out_avg_in;
      out_seed_ff  <= out_seed_in;
   end

   assign sts.seeded    = seeded_ff;
   assign sts.seed_last = seed_last;
   assign sts.div_last  = (cnt_ff == CW'(SUMW - 1));

   assign rsp_average = out_avg_ff;
   assign rsp_is_seed = out_seed_ff;

endmodule
